FILE: hw/rtl/nta_pkg.sv
package nta_pkg;

   localparam logic KIND_HELLO = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam logic       REG_TIMEOUT     = 1'b0;
   localparam logic [7:0] TIMEOUT_DEFAULT = 8'd40;
   localparam int         CNT_OUT_MAX     = 31;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_DONE
   } nta_state_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  iface;
      logic [31:0] sender_id;
      logic [31:0] sender_addr;
      logic [31:0] sender_mask;
   } nta_req_type;

   typedef struct packed {
      logic [1:0]  iface;
      logic [31:0] peer_id;
      logic [31:0] addr;
      logic [31:0] mask;
      logic [7:0]  lifetime;
   } nta_entry_type;

   typedef struct packed {
      logic       valid;
      logic       entry_refreshed;
      logic       entry_added;
      logic       table_full;
      logic [4:0] removed_count;
      logic [4:0] iface_neighbors;
      logic       topology_changed;
   } nta_rsp_type;

endpackage

FILE: hw/rtl/nta_ram.sv
module nta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/nta_csr.sv
module nta_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  timeout_ticks
);
   import nta_pkg::*;

   logic [7:0] timeout_ff;
   logic [7:0] timeout_in;
   logic       wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);

   always_comb begin
      timeout_in = timeout_ff;
      if (wr_hit) begin
         timeout_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_DEFAULT;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign prdata        = (paddr[2] == REG_TIMEOUT) ? {24'd0, timeout_ff} : 32'd0;
   assign timeout_ticks = timeout_ff;

endmodule

FILE: hw/rtl/nta_engine.sv
module nta_engine #(
   parameter int TABLE_DEPTH = 16,
   parameter int NUM_IFACES  = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  nta_pkg::nta_req_type req,
   input  logic [7:0]          timeout_ticks,
   output logic                busy,
   output nta_pkg::nta_rsp_type rsp
);
   import nta_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = $bits(nta_entry_type);

   nta_state_type state_ff, state_in;
   nta_req_type   req_ff, req_in;
   nta_rsp_type   rsp_ff, rsp_in;

   logic [AW:0]            cnt_ff, cnt_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [AW-1:0]          chk_idx_ff, chk_idx_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CW-1:0]          count_ff [NUM_IFACES];
   logic [CW-1:0]          count_in [NUM_IFACES];
   logic [CW-1:0]          removed_ff, removed_in;
   logic                   hit_ff, hit_in;
   logic [AW-1:0]          hit_idx_ff, hit_idx_in;
   nta_entry_type          hit_word_ff, hit_word_in;
   logic                   free_ff, free_in;
   logic [AW-1:0]          free_idx_ff, free_idx_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   nta_entry_type          wr_word;
   logic                   rd_en;
   logic [EW-1:0]          rd_data;
   nta_entry_type          rd_word;
   logic                   issue;
   logic                   ifc_ok;
   logic                   hello;
   logic [CW-1:0]          sel_count;
   nta_entry_type          new_word;

   nta_ram #(
      .WIDTH(EW),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_word),
      .rd_en  (rd_en),
      .rd_addr(cnt_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   assign rd_word = nta_entry_type'(rd_data);
   assign issue   = cnt_ff < (AW+1)'(TABLE_DEPTH);
   assign ifc_ok  = 32'(req_ff.iface) < NUM_IFACES;
   assign hello   = req_ff.kind == KIND_HELLO;
   assign busy    = state_ff != ST_IDLE;
   assign rsp     = rsp_ff;

   always_comb begin
      new_word.iface     = req_ff.iface;
      new_word.peer_id   = req_ff.sender_id;
      new_word.addr      = req_ff.sender_addr;
      new_word.mask      = req_ff.sender_mask;
      new_word.lifetime  = timeout_ticks;
   end

   always_comb begin
      sel_count = '0;
      for (int j = 0; j < NUM_IFACES; j++) begin
         if (32'(req_ff.iface) == j) begin
            sel_count = count_ff[j];
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      rsp_in      = '0;
      cnt_in      = cnt_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      valid_in    = valid_ff;
      count_in    = count_ff;
      removed_in  = removed_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_word_in = hit_word_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      wr_en       = 1'b0;
      wr_addr     = chk_idx_ff;
      wr_word     = rd_word;
      rd_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in     = req;
               cnt_in     = '0;
               removed_in = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               if (req.kind == KIND_HELLO && !(32'(req.iface) < NUM_IFACES)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (issue) begin
               rd_en      = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_ff[AW-1:0];
            end
            if (chk_vld_ff) begin
               if (!hello) begin
                  if (valid_ff[chk_idx_ff]) begin
                     if (rd_word.lifetime <= 8'd1) begin
                        valid_in[chk_idx_ff] = 1'b0;
                        removed_in           = removed_ff + 1'b1;
                        for (int j = 0; j < NUM_IFACES; j++) begin
                           if (32'(rd_word.iface) == j && count_ff[j] != '0) begin
                              count_in[j] = count_ff[j] - 1'b1;
                           end
                        end
                     end else begin
                        wr_en            = 1'b1;
                        wr_word.lifetime = rd_word.lifetime - 8'd1;
                     end
                  end
               end else begin
                  if (valid_ff[chk_idx_ff] && rd_word.iface == req_ff.iface &&
                      rd_word.peer_id == req_ff.sender_id) begin
                     hit_in      = 1'b1;
                     hit_idx_in  = chk_idx_ff;
                     hit_word_in = rd_word;
                  end
                  if (!valid_ff[chk_idx_ff] && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = chk_idx_ff;
                  end
               end
            end
            if (!issue && !chk_vld_ff) begin
               state_in = hello ? ST_COMMIT : ST_DONE;
            end
         end

         ST_COMMIT: begin
            if (hit_ff) begin
               wr_en            = 1'b1;
               wr_addr          = hit_idx_ff;
               wr_word          = hit_word_ff;
               wr_word.lifetime = timeout_ticks;
            end else if (free_ff) begin
               wr_en                 = 1'b1;
               wr_addr               = free_idx_ff;
               wr_word               = new_word;
               valid_in[free_idx_ff] = 1'b1;
               for (int j = 0; j < NUM_IFACES; j++) begin
                  if (32'(req_ff.iface) == j) begin
                     count_in[j] = count_ff[j] + 1'b1;
                  end
               end
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            rsp_in.valid           = 1'b1;
            rsp_in.entry_refreshed = hello && hit_ff;
            rsp_in.entry_added     = hello && !hit_ff && free_ff;
            rsp_in.table_full      = hello && ifc_ok && !hit_ff && !free_ff;
            rsp_in.removed_count   = (32'(removed_ff) > CNT_OUT_MAX) ? 5'(CNT_OUT_MAX)
                                                                    : 5'(removed_ff);
            rsp_in.iface_neighbors = (32'(sel_count) > CNT_OUT_MAX) ? 5'(CNT_OUT_MAX)
                                                                   : 5'(sel_count);
            rsp_in.topology_changed = hello ? (!hit_ff && free_ff) : (removed_ff != '0);
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         chk_vld_ff <= 1'b0;
         valid_ff   <= '0;
         count_ff   <= '{default: '0};
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         rsp_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         chk_vld_ff <= chk_vld_in;
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         hit_ff     <= hit_in;
         free_ff    <= free_in;
         rsp_ff     <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      chk_idx_ff  <= chk_idx_in;
      removed_ff  <= removed_in;
      hit_idx_ff  <= hit_idx_in;
      hit_word_ff <= hit_word_in;
      free_idx_ff <= free_idx_in;
   end

   // A result strobe follows only the final state of a transaction.
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid |-> $past(state_ff) == ST_DONE)
      else $error("result strobe without a finished transaction");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SCAN || state_ff == ST_COMMIT))
      else $error("table write outside scan or commit");

   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> state_ff == ST_SCAN)
      else $error("entry check pending outside the scan");

   a_tick_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && req_ff.kind == KIND_TICK) |->
      !(rsp_ff.entry_refreshed || rsp_ff.entry_added || rsp_ff.table_full))
      else $error("hello flags raised on a tick");

   // Placing a new neighbor must claim a previously free entry.
   a_add_claims: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && !hit_ff && free_ff) |=> valid_ff != $past(valid_ff))
      else $error("new neighbor did not claim an entry");

endmodule

FILE: hw/rtl/neighbor_table_aging.sv
// Neighbor table with dead-timer aging. A transaction is either a hello, which
// refreshes the matching neighbor on its interface or places it in the lowest
// free entry, or a tick, which ages every live entry and removes those that
// run out. Every tick and every hello on an interface below NUM_IFACES walks
// the whole table through the single read port of the table RAM, one entry
// per cycle; a hello on an interface at or beyond NUM_IFACES skips the walk.
// The result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, in the first cycle in which busy is low again; the receiver
// cannot stall it, so it must take every strobe. timeout_ticks is written
// through the APB port at byte address 0; the user must write it only while
// the block is idle, and the block itself does not enforce this.
module neighbor_table_aging #(
   parameter int TABLE_DEPTH = 16,
   parameter int NUM_IFACES  = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [1:0]  req_iface_index,
   input  logic [31:0] req_sender_id,
   input  logic [31:0] req_sender_addr,
   input  logic [31:0] req_sender_mask,
   output logic        rsp_valid,
   output logic        rsp_entry_refreshed,
   output logic        rsp_entry_added,
   output logic        rsp_table_full,
   output logic [4:0]  rsp_removed_count,
   output logic [4:0]  rsp_iface_neighbors,
   output logic        rsp_topology_changed,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import nta_pkg::*;

   nta_req_type req;
   nta_rsp_type rsp;
   logic [7:0]  timeout_ticks;

   always_comb begin
      req.kind        = req_kind;
      req.iface       = req_iface_index;
      req.sender_id   = req_sender_id;
      req.sender_addr = req_sender_addr;
      req.sender_mask = req_sender_mask;
   end

   nta_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .timeout_ticks(timeout_ticks)
   );

   nta_engine #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .NUM_IFACES (NUM_IFACES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req          (req),
      .timeout_ticks(timeout_ticks),
      .busy         (busy),
      .rsp          (rsp)
   );

   assign rsp_valid            = rsp.valid;
   assign rsp_entry_refreshed  = rsp.entry_refreshed;
   assign rsp_entry_added      = rsp.entry_added;
   assign rsp_table_full       = rsp.table_full;
   assign rsp_removed_count    = rsp.removed_count;
   assign rsp_iface_neighbors  = rsp.iface_neighbors;
   assign rsp_topology_changed = rsp.topology_changed;

endmodule

FILE: tb/tb_neighbor_table_aging.sv
`default_nettype none

module tb_neighbor_table_aging;
   timeunit 1ns;
   timeprecision 1ps;

   import nta_pkg::*;

   localparam int          TABLE_SIZE     = 16;
   localparam int          IFACE_COUNT    = 4;
   localparam int          SETTLE_CYCLES  = TABLE_SIZE + 8;
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          ID_POOL_SIZE   = 24;
   localparam logic [2:0]  ADDR_TIMEOUT   = {REG_TIMEOUT, 2'b00};
   localparam logic [2:0]  ADDR_SPARE     = 3'd4;
   localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

   logic        clock;
   logic        reset           = 1'b1;
   logic        start           = 1'b0;
   logic        busy;
   logic        req_kind        = KIND_HELLO;
   logic [1:0]  req_iface_index = '0;
   logic [31:0] req_sender_id   = '0;
   logic [31:0] req_sender_addr = '0;
   logic [31:0] req_sender_mask = '0;
   logic        rsp_valid;
   logic        rsp_entry_refreshed;
   logic        rsp_entry_added;
   logic        rsp_table_full;
   logic [4:0]  rsp_removed_count;
   logic [4:0]  rsp_iface_neighbors;
   logic        rsp_topology_changed;
   logic        psel            = 1'b0;
   logic        penable         = 1'b0;
   logic        pwrite          = 1'b0;
   logic [2:0]  paddr           = '0;
   logic [31:0] pwdata          = '0;
   logic [31:0] prdata;
   logic        pready;

   neighbor_table_aging #(
      .TABLE_DEPTH(TABLE_SIZE),
      .NUM_IFACES (IFACE_COUNT)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_iface_index     (req_iface_index),
      .req_sender_id       (req_sender_id),
      .req_sender_addr     (req_sender_addr),
      .req_sender_mask     (req_sender_mask),
      .rsp_valid           (rsp_valid),
      .rsp_entry_refreshed (rsp_entry_refreshed),
      .rsp_entry_added     (rsp_entry_added),
      .rsp_table_full      (rsp_table_full),
      .rsp_removed_count   (rsp_removed_count),
      .rsp_iface_neighbors (rsp_iface_neighbors),
      .rsp_topology_changed(rsp_topology_changed),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // Mirror of the neighbor table and the timeout register.
   logic [7:0]  timeout_shadow = TIMEOUT_DEFAULT;
   bit          nbr_valid [TABLE_SIZE];
   logic [1:0]  nbr_iface [TABLE_SIZE];
   logic [31:0] nbr_id    [TABLE_SIZE];
   logic [31:0] nbr_addr  [TABLE_SIZE];
   logic [31:0] nbr_netmask [TABLE_SIZE];
   logic [7:0]  nbr_life  [TABLE_SIZE];
   int unsigned iface_total [IFACE_COUNT];

   nta_rsp_type expected_results[$];
   logic [31:0] id_pool [ID_POOL_SIZE];
   bit          gaps_on = 1'b1;
   int          fail_count = 0;
   int          idle_cycles = 0;
   int          hello_count = 0, tick_count = 0, added_count = 0;
   int          refreshed_count = 0, full_count = 0, expired_count = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [4:0] sat_count(input int unsigned v);
      return (v > CNT_OUT_MAX) ? 5'(CNT_OUT_MAX) : 5'(v);
   endfunction

   function automatic nta_req_type make_op(input logic kind, input logic [1:0] iface,
                                           input logic [31:0] id, input logic [31:0] addr,
                                           input logic [31:0] mask);
      nta_req_type op;
      op.kind        = kind;
      op.iface       = iface;
      op.sender_id   = id;
      op.sender_addr = addr;
      op.sender_mask = mask;
      return op;
   endfunction

   function automatic nta_rsp_type predict_neighbor_step(input nta_req_type op);
      nta_rsp_type r;
      bit          hit;
      int unsigned expired;
      r       = '0;
      r.valid = 1'b1;
      hit     = 1'b0;
      expired = 0;
      if (op.kind == KIND_HELLO) begin
         hello_count++;
         if (op.iface < IFACE_COUNT) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
               if (!hit && nbr_valid[i] && nbr_iface[i] == op.iface &&
                   nbr_id[i] == op.sender_id) begin
                  nbr_life[i] = timeout_shadow;
                  hit = 1'b1;
               end
            end
            if (hit) begin
               r.entry_refreshed = 1'b1;
               refreshed_count++;
            end else begin
               for (int i = 0; i < TABLE_SIZE; i++) begin
                  if (!r.entry_added && !nbr_valid[i]) begin
                     nbr_valid[i]   = 1'b1;
                     nbr_iface[i]   = op.iface;
                     nbr_id[i]      = op.sender_id;
                     nbr_addr[i]    = op.sender_addr;
                     nbr_netmask[i] = op.sender_mask;
                     nbr_life[i]    = timeout_shadow;
                     iface_total[op.iface]++;
                     r.entry_added = 1'b1;
                  end
               end
               if (r.entry_added) begin
                  r.topology_changed = 1'b1;
                  added_count++;
               end else begin
                  r.table_full = 1'b1;
                  full_count++;
               end
            end
         end
      end else begin
         tick_count++;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            if (nbr_valid[i]) begin
               // A lifetime of zero or one runs out on this tick.
               if (nbr_life[i] <= 8'd1) begin
                  nbr_valid[i] = 1'b0;
                  nbr_life[i]  = '0;
                  if (iface_total[nbr_iface[i]] > 0) iface_total[nbr_iface[i]]--;
                  expired++;
               end else begin
                  nbr_life[i] = nbr_life[i] - 8'd1;
               end
            end
         end
         expired_count += expired;
         r.removed_count    = sat_count(expired);
         r.topology_changed = (expired != 0);
      end
      r.iface_neighbors = (op.iface < IFACE_COUNT) ? sat_count(iface_total[op.iface]) : '0;
      return r;
   endfunction

   // Sends one transaction after a random gap; start stays high afterwards so that
   // back-to-back transactions never drop it.
   task automatic issue_op(input nta_req_type op);
      int gap;
      gap = gaps_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_kind        <= op.kind;
      req_iface_index <= op.iface;
      req_sender_id   <= op.sender_id;
      req_sender_addr <= op.sender_addr;
      req_sender_mask <= op.sender_mask;
      do @(posedge clock); while (busy !== 1'b0);
      expected_results.push_back(predict_neighbor_step(op));
   endtask

   task automatic drain_and_settle();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr == ADDR_TIMEOUT) timeout_shadow = data[7:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_timeout_readback();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_TIMEOUT;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[7:0] !== timeout_shadow) begin
         $error("timeout_ticks readback: expected %0d, actual %0d",
                timeout_shadow, prdata[7:0]);
         fail_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_timeout(input logic [7:0] value);
      drain_and_settle();
      csr_write(ADDR_TIMEOUT, {24'h0, value});
      check_timeout_readback();
   endtask

   task automatic test_register_access();
      check_timeout_readback();
      // Only register 0 exists; a write to the next slot must leave it alone.
      csr_write(ADDR_SPARE, ALL_ONES);
      check_timeout_readback();
   endtask

   task automatic test_hello_and_refresh();
      issue_op(make_op(KIND_TICK, 2'd0, ALL_ONES, ALL_ONES, ALL_ONES));
      issue_op(make_op(KIND_HELLO, 2'd0, 32'h0, 32'h0, 32'h0));
      issue_op(make_op(KIND_HELLO, 2'd3, ALL_ONES, ALL_ONES, ALL_ONES));
      issue_op(make_op(KIND_HELLO, 2'd1, 32'h0A00_0001, 32'hC0A8_0101, 32'hFFFF_FF00));
      issue_op(make_op(KIND_HELLO, 2'd2, ALL_ONES, 32'h5555_5555, 32'hAAAA_AAAA));
      // A new address and mask on a known neighbor only renews its lifetime.
      issue_op(make_op(KIND_HELLO, 2'd0, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555));
      // The same router id on another interface is a different neighbor.
      issue_op(make_op(KIND_HELLO, 2'd1, 32'h0, 32'h0A0A_0A0A, 32'hFFFF_0000));
   endtask

   task automatic test_table_full();
      set_timeout(8'd2);
      for (int i = 0; i < TABLE_SIZE - 5; i++)
         issue_op(make_op(KIND_HELLO, 2'd2, 32'd100 + i, $urandom, $urandom));
      issue_op(make_op(KIND_HELLO, 2'd3, 32'h1234_5678, $urandom, $urandom));
      issue_op(make_op(KIND_HELLO, 2'd3, ALL_ONES, $urandom, $urandom));
      issue_op(make_op(KIND_TICK, 2'd2, $urandom, $urandom, $urandom));
      issue_op(make_op(KIND_TICK, 2'd3, $urandom, $urandom, $urandom));
   endtask

   task automatic test_zero_timeout();
      set_timeout(8'd0);
      issue_op(make_op(KIND_HELLO, 2'd1, 32'hDEAD_0001, $urandom, $urandom));
      issue_op(make_op(KIND_TICK, 2'd1, $urandom, $urandom, $urandom));
   endtask

   task automatic test_random_traffic(input int count, input logic [7:0] timeout,
                                      input int tick_percent);
      nta_req_type op;
      set_timeout(timeout);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         op = make_op(KIND_HELLO, 2'($urandom_range(0, 3)), 32'h0, $urandom, $urandom);
         if ($urandom_range(0, 99) < tick_percent) op.kind = KIND_TICK;
         // Mostly known router ids so that hellos refresh as often as they add.
         op.sender_id = ($urandom_range(0, 9) == 0) ? $urandom
                                                    : id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
         issue_op(op);
      end
   endtask

   always @(posedge clock) begin : check_results
      nta_rsp_type exp_r;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("result arrived with no transaction outstanding");
            fail_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_entry_refreshed !== exp_r.entry_refreshed) begin
               $error("entry_refreshed: expected %0d, actual %0d",
                      exp_r.entry_refreshed, rsp_entry_refreshed);
               fail_count++;
            end
            if (rsp_entry_added !== exp_r.entry_added) begin
               $error("entry_added: expected %0d, actual %0d",
                      exp_r.entry_added, rsp_entry_added);
               fail_count++;
            end
            if (rsp_table_full !== exp_r.table_full) begin
               $error("table_full: expected %0d, actual %0d",
                      exp_r.table_full, rsp_table_full);
               fail_count++;
            end
            if (rsp_removed_count !== exp_r.removed_count) begin
               $error("removed_count: expected %0d, actual %0d",
                      exp_r.removed_count, rsp_removed_count);
               fail_count++;
            end
            if (rsp_iface_neighbors !== exp_r.iface_neighbors) begin
               $error("iface_neighbors: expected %0d, actual %0d",
                      exp_r.iface_neighbors, rsp_iface_neighbors);
               fail_count++;
            end
            if (rsp_topology_changed !== exp_r.topology_changed) begin
               $error("topology_changed: expected %0d, actual %0d",
                      exp_r.topology_changed, rsp_topology_changed);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1 ||
          (psel === 1'b1 && penable === 1'b1 && pready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) nbr_valid[i] = 1'b0;
      for (int i = 0; i < IFACE_COUNT; i++) iface_total[i] = 0;
      id_pool[0] = 32'h0;
      id_pool[1] = ALL_ONES;
      for (int i = 2; i < ID_POOL_SIZE; i++) id_pool[i] = $urandom;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_register_access();
      test_hello_and_refresh();
      test_table_full();
      test_zero_timeout();
      test_random_traffic(200, 8'd255, 20);
      test_random_traffic(200, 8'd1, 30);
      test_random_traffic(200, 8'd0, 25);
      test_random_traffic(200, 8'd3, 30);
      test_random_traffic(200, 8'd8, 25);
      test_random_traffic(200, 8'($urandom_range(1, 255)), 45);
      test_random_traffic(200, 8'($urandom_range(1, 20)), 30);
      test_random_traffic(200, TIMEOUT_DEFAULT, 60);

      drain_and_settle();
      $display("Covered %0d hellos (%0d added, %0d refreshed, %0d dropped on a full table)",
               hello_count, added_count, refreshed_count, full_count);
      $display("and %0d ticks that expired %0d neighbors.", tick_count, expired_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
